// ===== rtl/skvt_pkg.sv =====
package skvt_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_BITS  = 32;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int CNT_OUT_W   = 7;
    // stored value width: the value field is 32 bits, so nothing above that survives
    localparam int STORE_W     = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_FIND   = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic                 hit;
        logic [VAL_W-1:0]     read_value;
        logic                 dropped;
        logic [CNT_OUT_W-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [STORE_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_cmd;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SRCH  = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_CHK   = 8'b0000_1000,
        S_ACT   = 8'b0001_0000,
        S_SHIFT = 8'b0010_0000,
        S_PLACE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

// ===== rtl/skvt_store.sv =====
module skvt_store (
    input  logic                i_clk,
    input  skvt_pkg::t_ram_cmd  i_cmd,
    output skvt_pkg::t_entry    o_rdata
);

    skvt_pkg::t_entry r_mem [skvt_pkg::CAPACITY];
    skvt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/skvt_seq.sv =====
module skvt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  skvt_pkg::t_in      i_req,
    output logic               o_idle,
    output skvt_pkg::t_ram_cmd o_ram,
    input  skvt_pkg::t_entry   i_rdata,
    input  logic               i_out_free,
    output logic               o_done,
    output skvt_pkg::t_out     o_res
);

    localparam int CW = skvt_pkg::COUNT_W;
    localparam int IW = skvt_pkg::IDX_W;
    localparam int SW = skvt_pkg::STORE_W;
    localparam int VW = skvt_pkg::VAL_W;
    localparam int OW = skvt_pkg::CNT_OUT_W;

    skvt_pkg::t_state r_state, n_state;
    skvt_pkg::t_in    r_req, n_req;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [CW-1:0]    r_pos, n_pos;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_found, n_found;
    logic [SW-1:0]    r_val, n_val;
    logic             r_hit, n_hit;
    logic [VW-1:0]    r_rd, n_rd;
    logic             r_drop, n_drop;

    logic             key_lt;
    logic             key_eq;
    logic [CW-1:0]    mid_c;
    skvt_pkg::t_entry new_entry;
    logic [SW+VW-1:0] val_ext;
    logic [CW+OW-1:0] cnt_ext;

    // shared compare unit
    assign key_lt = i_rdata.key < r_req.key;
    assign key_eq = i_rdata.key == r_req.key;
    assign mid_c  = r_lo + ((r_hi - r_lo) >> 1);

    assign new_entry.key   = r_req.key;
    assign new_entry.value = r_req.value[SW-1:0];

    assign val_ext = {{VW{1'b0}}, r_val};
    assign cnt_ext = {{OW{1'b0}}, r_count};

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_pos   = r_pos;
        n_count = r_count;
        n_idx   = r_idx;
        n_found = r_found;
        n_val   = r_val;
        n_hit   = r_hit;
        n_rd    = r_rd;
        n_drop  = r_drop;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_pos[IW-1:0];
        o_ram.wdata = new_entry;
        o_ram.raddr = r_lo[IW-1:0];
        o_done      = 1'b0;

        unique case (r_state)
            skvt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = skvt_pkg::S_SRCH;
                end
            end
            skvt_pkg::S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid       = mid_c;
                    o_ram.raddr = mid_c[IW-1:0];
                    n_state     = skvt_pkg::S_CMP;
                end else begin
                    n_pos = r_lo;
                    if (r_lo < r_count) begin
                        n_state = skvt_pkg::S_CHK;
                    end else begin
                        n_found = 1'b0;
                        n_state = skvt_pkg::S_ACT;
                    end
                end
            end
            skvt_pkg::S_CMP: begin
                if (key_lt) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi = r_mid;
                end
                n_state = skvt_pkg::S_SRCH;
            end
            skvt_pkg::S_CHK: begin
                n_found = key_eq;
                n_val   = i_rdata.value;
                n_state = skvt_pkg::S_ACT;
            end
            skvt_pkg::S_ACT: begin
                n_hit   = r_found;
                n_rd    = '0;
                n_drop  = 1'b0;
                n_state = skvt_pkg::S_DONE;
                if (r_req.req_type == skvt_pkg::REQ_FIND) begin
                    if (r_found) begin
                        n_rd = val_ext[VW-1:0];
                    end
                end else if (r_found) begin
                    o_ram.we = 1'b1;
                end else if (r_count == CW'(skvt_pkg::CAPACITY)) begin
                    n_drop = 1'b1;
                end else if (r_pos < r_count) begin
                    n_idx       = IW'(r_count - CW'(1));
                    o_ram.raddr = IW'(r_count - CW'(1));
                    n_state     = skvt_pkg::S_SHIFT;
                end else begin
                    n_state = skvt_pkg::S_PLACE;
                end
            end
            skvt_pkg::S_SHIFT: begin
                // move one entry up per cycle, top down
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx + IW'(1);
                o_ram.wdata = i_rdata;
                o_ram.raddr = r_idx - IW'(1);
                if (r_idx == r_pos[IW-1:0]) begin
                    n_state = skvt_pkg::S_PLACE;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            skvt_pkg::S_PLACE: begin
                o_ram.we = 1'b1;
                n_count  = r_count + CW'(1);
                n_state  = skvt_pkg::S_DONE;
            end
            skvt_pkg::S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = skvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skvt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvt_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req   <= n_req;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_pos   <= n_pos;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_val   <= n_val;
        r_hit   <= n_hit;
        r_rd    <= n_rd;
        r_drop  <= n_drop;
    end

    assign o_idle = (r_state == skvt_pkg::S_IDLE);

    assign o_res.hit         = r_hit;
    assign o_res.read_value  = r_rd;
    assign o_res.dropped     = r_drop;
    assign o_res.entry_count = cnt_ext[OW-1:0];

endmodule

// ===== rtl/sorted_key_value_table.sv =====
// the time from request beat to result beat grows with the search steps (up to clog2(count+1),
//   7 on a full table) and, for a new-key insert, with the entries moved up
// requests are taken one at a time: a new request beat waits until the search/shift
//   sequencer is idle again
// a held result stalls the sequencer only once the output register is full as well
// reset: synchronous active low, empties the table (count to zero); entry storage is not cleared
module sorted_key_value_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  skvt_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output skvt_pkg::t_out o_data
);

    // sequencer <-> entry store
    skvt_pkg::t_ram_cmd ram_cmd;
    skvt_pkg::t_entry   ram_rdata;

    // sequencer <-> output register
    logic               seq_idle;
    logic               seq_done;
    skvt_pkg::t_out     seq_res;
    logic               out_free;

    // output register, parts the result side from the sequencer
    logic               r_out_valid;
    skvt_pkg::t_out     r_out;

    // a request beat is taken only while the sequencer sits idle
    assign o_ready  = seq_idle;
    assign out_free = !r_out_valid || i_ready;

    skvt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && seq_idle),
        .i_req      (i_data),
        .o_idle     (seq_idle),
        .o_ram      (ram_cmd),
        .i_rdata    (ram_rdata),
        .i_out_free (out_free),
        .o_done     (seq_done),
        .o_res      (seq_res)
    );

    // key/value pairs, one write and one registered read per cycle
    skvt_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (ram_cmd),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (seq_done) begin
            r_out <= seq_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// ===== bench/sorted_key_value_table_test.sv =====
module sorted_key_value_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    // stimulus sizes and run limits
    localparam int RANDOM_ITEMS  = 1233;
    localparam int STALL_LIMIT   = 4000;   // cycles with no beat on either side
    localparam int HOLD_CYCLES   = 600;    // long receiver hold-off
    localparam int HOLD_AT       = 200;    // results seen before the hold-off starts
    localparam int TAIL_CYCLES   = 100;    // covers the slowest insert with a full shift
    localparam int MAX_REPORTS   = 10;
    localparam logic [skvt_pkg::VAL_W-1:0] STORE_MASK =
        skvt_pkg::VAL_W'((64'd1 << skvt_pkg::STORE_W) - 1);
    localparam logic [skvt_pkg::KEY_W-1:0] KEY_MAX    = '1;
    localparam logic [skvt_pkg::KEY_W-1:0] KEY_MID    = {1'b1, {(skvt_pkg::KEY_W-1){1'b0}}};

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_ready = 1'b0;
    skvt_pkg::t_in  i_data  = '0;
    logic           o_ready;
    logic           o_valid;
    skvt_pkg::t_out o_data;

    // shadow copy of the table contents
    logic [skvt_pkg::KEY_W-1:0] table_keys [skvt_pkg::CAPACITY];
    logic [skvt_pkg::VAL_W-1:0] table_vals [skvt_pkg::CAPACITY];
    int                         table_count = 0;

    skvt_pkg::t_in              pending_items    [$];
    skvt_pkg::t_out             expected_results [$];
    logic [skvt_pkg::KEY_W-1:0] known_keys       [$];

    int items_accepted = 0;
    int results_seen   = 0;
    int total_items    = 0;
    int faults         = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int quiet_cycles   = 0;
    bit sender_calm;
    bit receiver_calm;
    bit input_waiting;

    sorted_key_value_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one request to the shadow table and return the result it should give
    function automatic skvt_pkg::t_out table_apply(skvt_pkg::t_in req);
        skvt_pkg::t_out res;
        int             slot;
        logic           present;
        res  = '0;
        slot = 0;
        // first entry whose key is not below the request key
        while (slot < table_count && table_keys[slot] < req.key)
            slot++;
        present = (slot < table_count) && (table_keys[slot] == req.key);
        res.hit = present;
        if (req.req_type == skvt_pkg::REQ_FIND) begin
            if (present)
                res.read_value = table_vals[slot];
        end else if (present) begin
            table_vals[slot] = req.value & STORE_MASK;
        end else if (table_count == skvt_pkg::CAPACITY) begin
            // new key with no room left: table untouched
            res.dropped = 1'b1;
        end else begin
            for (int j = table_count; j > slot; j--) begin
                table_keys[j] = table_keys[j-1];
                table_vals[j] = table_vals[j-1];
            end
            table_keys[slot] = req.key;
            table_vals[slot] = req.value & STORE_MASK;
            table_count++;
        end
        res.entry_count = skvt_pkg::CNT_OUT_W'(table_count);
        return res;
    endfunction

    // a key that is probably not yet in the table, sometimes right next to one that is
    function automatic logic [skvt_pkg::KEY_W-1:0] fresh_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20 && known_keys.size() != 0) begin
            if ($urandom_range(1))
                return known_keys[$urandom_range(known_keys.size() - 1)] + 1'b1;
            else
                return known_keys[$urandom_range(known_keys.size() - 1)] - 1'b1;
        end
        if (pick < 40)
            return skvt_pkg::KEY_W'($urandom_range(63));
        return {$urandom, $urandom};
    endfunction

    task automatic queue_item(logic req, logic [skvt_pkg::KEY_W-1:0] key,
                              logic [skvt_pkg::VAL_W-1:0] value);
        skvt_pkg::t_in item;
        item.req_type = req;
        item.key      = key;
        item.value    = value;
        pending_items.push_back(item);
        if (req == skvt_pkg::REQ_INSERT)
            known_keys.push_back(key);
        total_items++;
    endtask

    // sender: offers the next queued item, idling at random outside the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            input_waiting = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                expected_results.push_back(table_apply(i_data));
                items_accepted++;
            end
            // a beat still waiting keeps valid and payload as they are
            if (!input_waiting) begin
                sender_calm = items_accepted >= 500 && items_accepted < 650;
                if (pending_items.size() != 0 && (sender_calm || $urandom_range(99) >= 36)) begin
                    i_data  <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result beat against the oldest expectation and drives ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("unexpected result beat: hit=%0b rd=%h drop=%0b count=%0d",
                                 o_data.hit, o_data.read_value, o_data.dropped,
                                 o_data.entry_count);
                end else begin
                    skvt_pkg::t_out want;
                    want = expected_results.pop_front();
                    if (o_data.hit !== want.hit || o_data.read_value !== want.read_value ||
                        o_data.dropped !== want.dropped ||
                        o_data.entry_count !== want.entry_count) begin
                        faults++;
                        if (faults <= MAX_REPORTS) begin
                            $write("result %0d mismatch: expected hit=%0b rd=%h drop=%0b count=%0d",
                                   results_seen, want.hit, want.read_value, want.dropped,
                                   want.entry_count);
                            $display(", got hit=%0b rd=%h drop=%0b count=%0d",
                                     o_data.hit, o_data.read_value, o_data.dropped,
                                     o_data.entry_count);
                        end
                    end
                end
                results_seen++;
            end
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            receiver_calm = results_seen >= 900 && results_seen < 1050;
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= receiver_calm || ($urandom_range(99) >= 36);
            end
        end
    end

    // watchdog: too long without a beat on either side means the block has hung
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int                         roll;
        logic [skvt_pkg::KEY_W-1:0] key;

        // directed: empty table, key extremes, shifts into the middle, updates, misses
        queue_item(skvt_pkg::REQ_FIND,   '0,             32'h0000_0000);
        queue_item(skvt_pkg::REQ_INSERT, KEY_MAX,        32'hFFFF_FFFF);
        queue_item(skvt_pkg::REQ_INSERT, '0,             32'h0000_0000);
        queue_item(skvt_pkg::REQ_INSERT, KEY_MID,        32'hA5A5_5A5A);
        queue_item(skvt_pkg::REQ_INSERT, KEY_MID - 1'b1, 32'h1234_5678);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MAX,        32'h0000_0000);
        queue_item(skvt_pkg::REQ_FIND,   '0,             32'hFFFF_FFFF);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MID - 1'b1, 32'h0000_0000);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MID + 1'b1, 32'h0000_0000);
        queue_item(skvt_pkg::REQ_FIND,   64'd1,          32'h0000_0000);
        queue_item(skvt_pkg::REQ_INSERT, '0,             32'hFFFF_FFFF);
        queue_item(skvt_pkg::REQ_FIND,   '0,             32'h0000_0000);
        queue_item(skvt_pkg::REQ_INSERT, KEY_MAX,        32'h0000_0000);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MAX,        32'h5555_AAAA);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MAX - 1'b1, 32'h0000_0000);
        queue_item(skvt_pkg::REQ_INSERT, KEY_MAX - 1'b1, 32'h8000_0001);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MAX - 1'b1, 32'h0000_0000);
        queue_item(skvt_pkg::REQ_FIND,   KEY_MID,        32'hDEAD_BEEF);
        queue_item(skvt_pkg::REQ_INSERT, 64'd1,          32'h0000_0001);

        // random: new keys fill the table, then the full-table cases take over
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 18) begin
                queue_item(skvt_pkg::REQ_INSERT, fresh_key(), $urandom);
            end else if (roll < 45) begin
                key = known_keys[$urandom_range(known_keys.size() - 1)];
                queue_item(skvt_pkg::REQ_INSERT, key, $urandom);
            end else if (roll < 85) begin
                key = known_keys[$urandom_range(known_keys.size() - 1)];
                queue_item(skvt_pkg::REQ_FIND, key, $urandom);
            end else begin
                queue_item(skvt_pkg::REQ_FIND, fresh_key(), $urandom);
            end
        end

        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sampled away from the rising edge so every beat of that edge is counted
        do
            @(negedge i_clk);
        while (items_accepted != total_items || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
